/* hw/rtl/lehmer_random_range_dice_defines.svh */
// Assertion macros shared by the random range and dice unit.
`ifndef LEHMER_RANDOM_RANGE_DICE_DEFINES_SVH
`define LEHMER_RANDOM_RANGE_DICE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define LRRD_ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |-> (conseq)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define LRRD_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> (conseq)) else $error(msg);

`endif

/* hw/rtl/lrrd_pkg.sv */
// Types and constants of the random range and dice unit.
`default_nettype none

package lrrd_pkg;

	// Operation codes carried by each input item
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_RAW   = 2'd1,
		OP_RANGE = 2'd2,
		OP_DICE  = 2'd3
	} lrrd_op_t;

	localparam int DRAW_W = 31;  // generator state width
	localparam int VAL_W  = 32;  // result width
	localparam int SPAN_W = 33;  // range span width, up to 2^32
	localparam int PROD_W = 46;  // 31 x 15 bit product

	localparam logic [DRAW_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
	localparam logic [14:0]       LCG_MULT = 15'd16807;

	// Status of each arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} lrrd_unit_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/lehmer_random_range_dice.sv */
// Top level of the random range and dice unit: sequencer and output register.
//
//  channel | signals                                                  | dir
//  --------+----------------------------------------------------------+----
//  in      | in_valid, in_ready, opcode, seed_value, range_low,       | in
//          | range_high, dice_count, dice_faces                       |
//  out     | out_valid, out_ready, value                              | out
//
// Seed load: taken into the generator state in idle. Raw draw: the step unit
// (multiply, then fold), then posting the result. Range draw: step unit, then
// 31-bit serial remainder with its start and done registers, then posting;
// equal bounds go straight to posting. Dice sum: step unit and remainder per
// die, up to MAX_DICE_COUNT dice; zero count or faces go straight to posting.
// The remainder unit's one-bit-per-cycle loop dominates. in_ready is high only
// between items. Reset clears the generator state to zero. A stalled result
// waits in the output register while the next item is taken and worked on.
`default_nettype none
`include "lehmer_random_range_dice_defines.svh"

module lehmer_random_range_dice #(
	parameter int MAX_DICE_COUNT = 255
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [30:0] seed_value,
	input  wire logic [31:0] range_low,
	input  wire logic [31:0] range_high,
	input  wire logic [7:0]  dice_count,
	input  wire logic [15:0] dice_faces,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      value
);
	import lrrd_pkg::*;

	localparam int CNT_W = $clog2(MAX_DICE_COUNT + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADV,
		S_MOD,
		S_FIN
	} state_t;

	state_t            state_q;
	lrrd_op_t          op_q;
	logic [DRAW_W-1:0] rng_q;
	logic              lcg_start_q;
	logic              rem_start_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  value_q;
	logic [VAL_W-1:0]  res_q;
	logic [VAL_W-1:0]  sum_q;
	logic [VAL_W-1:0]  lo_q;
	logic [SPAN_W-1:0] span_q;
	logic [CNT_W-1:0]  count_q;

	lrrd_op_t          op_in;
	logic              lo_gt_hi;
	logic [VAL_W-1:0]  b_lo;
	logic [VAL_W-1:0]  b_hi;
	logic [SPAN_W-1:0] span_in;
	logic [CNT_W-1:0]  count_in;
	logic [VAL_W-1:0]  sum_next;
	logic              out_free;
	logic              lcg_go;
	logic              rem_go;

	logic [DRAW_W-1:0] lcg_result;
	lrrd_unit_stat_t   lcg_stat;
	logic [VAL_W-1:0]  rem_result;
	lrrd_unit_stat_t   rem_stat;

	lrrd_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lcg_start_q),
		.seed   (rng_q),
		.result (lcg_result),
		.stat   (lcg_stat)
	);

	lrrd_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start_q),
		.dividend  (rng_q),
		.divisor   (span_q),
		.remainder (rem_result),
		.stat      (rem_stat)
	);

	// Order the bounds and size the span at 33 bits
	always_comb begin
		op_in    = lrrd_op_t'(opcode);
		lo_gt_hi = $signed(range_low) > $signed(range_high);
		b_lo     = lo_gt_hi ? range_high : range_low;
		b_hi     = lo_gt_hi ? range_low : range_high;
		span_in  = {b_hi[VAL_W-1], b_hi} - {b_lo[VAL_W-1], b_lo} + SPAN_W'(1);
		if (32'(dice_count) > 32'(MAX_DICE_COUNT)) begin
			count_in = CNT_W'(MAX_DICE_COUNT);
		end else begin
			count_in = CNT_W'(dice_count);
		end
		sum_next = sum_q + rem_result + VAL_W'(1);
		out_free = !out_valid_q || out_ready;
		// Start the step unit for a new draw or the next die; start the remainder after a range or dice draw
		lcg_go = ((state_q == S_IDLE) && in_valid
			&& ((op_in == OP_RAW)
			|| (op_in == OP_RANGE && range_low != range_high)
			|| (op_in == OP_DICE && dice_count != '0 && dice_faces != '0)))
			|| ((state_q == S_MOD) && rem_stat.done && (op_q == OP_DICE)
			&& (count_q != CNT_W'(1)));
		rem_go = (state_q == S_ADV) && lcg_stat.done && (op_q != OP_RAW);
	end

	// Sequencer, generator state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_LOAD;
			rng_q       <= '0;
			lcg_start_q <= 1'b0;
			rem_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			res_q       <= '0;
			sum_q       <= '0;
			lo_q        <= '0;
			span_q      <= '0;
			count_q     <= '0;
		end else begin
			lcg_start_q <= lcg_go;
			rem_start_q <= rem_go;
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= op_in;
						unique case (op_in)
							OP_LOAD: begin
								rng_q <= seed_value;
							end
							OP_RAW: begin
								state_q <= S_ADV;
							end
							OP_RANGE: begin
								lo_q   <= b_lo;
								span_q <= span_in;
								if (range_low == range_high) begin
									res_q   <= range_low;
									state_q <= S_FIN;
								end else begin
									state_q <= S_ADV;
								end
							end
							OP_DICE: begin
								span_q  <= SPAN_W'(dice_faces);
								count_q <= count_in;
								sum_q   <= '0;
								if (dice_count == '0 || dice_faces == '0) begin
									res_q   <= '0;
									state_q <= S_FIN;
								end else begin
									state_q <= S_ADV;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADV: begin
					if (lcg_stat.done) begin
						rng_q <= lcg_result;
						if (op_q == OP_RAW) begin
							res_q   <= VAL_W'(lcg_result);
							state_q <= S_FIN;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (rem_stat.done) begin
						if (op_q == OP_RANGE) begin
							res_q   <= rem_result + lo_q;
							state_q <= S_FIN;
						end else if (count_q == CNT_W'(1)) begin
							res_q   <= sum_next;
							state_q <= S_FIN;
						end else begin
							sum_q   <= sum_next;
							count_q <= count_q - CNT_W'(1);
							state_q <= S_ADV;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						value_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;

	`LRRD_ASSERT_SAME(a_idle_units, in_ready, !lcg_stat.busy && !rem_stat.busy, "unit busy while idle")
	`LRRD_ASSERT_SAME(a_draw_nonzero, lcg_stat.done, lcg_result != '0, "generator produced zero")
	`LRRD_ASSERT_SAME(a_rem_bound, rem_stat.done, {1'b0, rem_result} < span_q, "remainder not below divisor")
	`LRRD_ASSERT_NEXT(a_fin_delivers, state_q == S_FIN && out_free, out_valid && in_ready, "result not posted")

endmodule

`default_nettype wire

/* hw/rtl/lrrd_lcg.sv */
// Generator step unit: state * 16807 mod (2^31 - 1), zero mapped to the modulus.
`default_nettype none

module lrrd_lcg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [lrrd_pkg::DRAW_W-1:0]     seed,
	output logic      [lrrd_pkg::DRAW_W-1:0]     result,
	output lrrd_pkg::lrrd_unit_stat_t            stat
);
	import lrrd_pkg::*;

	logic              v_s1;
	logic              v_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [DRAW_W:0]   fold_s2;
	logic [DRAW_W:0]   red;

	// Track the two stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	// Multiply, then fold the high part back in (2^31 == 1 mod the modulus)
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_W'(seed) * PROD_W'(LCG_MULT);
		end
		if (v_s1) begin
			fold_s2 <= (DRAW_W+1)'(prod_s1[DRAW_W-1:0])
				+ (DRAW_W+1)'(prod_s1[PROD_W-1:DRAW_W]);
		end
	end

	// Reduce once; a zero remainder becomes the modulus
	always_comb begin
		if (fold_s2 >= {1'b0, LCG_MOD}) begin
			red = fold_s2 - {1'b0, LCG_MOD};
		end else begin
			red = fold_s2;
		end
		if (red[DRAW_W-1:0] == '0) begin
			result = LCG_MOD;
		end else begin
			result = red[DRAW_W-1:0];
		end
	end

	assign stat.busy = v_s1 | v_s2;
	assign stat.done = v_s2;

endmodule

`default_nettype wire

/* hw/rtl/lrrd_rem.sv */
// Bit-serial remainder unit: one dividend bit per cycle, restoring.
`default_nettype none

module lrrd_rem (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [lrrd_pkg::DRAW_W-1:0]     dividend,
	input  wire logic [lrrd_pkg::SPAN_W-1:0]     divisor,
	output logic      [lrrd_pkg::VAL_W-1:0]      remainder,
	output lrrd_pkg::lrrd_unit_stat_t            stat
);
	import lrrd_pkg::*;

	localparam int STEP_W = $clog2(DRAW_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DRAW_W-1:0] dvd_q;
	logic [VAL_W-1:0]  rem_q;
	logic [SPAN_W-1:0] trial;
	logic [VAL_W-1:0]  rem_next;

	// Shift in the next dividend bit and subtract where it fits
	always_comb begin
		trial = {rem_q, dvd_q[DRAW_W-1]};
		if (trial >= divisor) begin
			rem_next = VAL_W'(trial - divisor);
		end else begin
			rem_next = trial[VAL_W-1:0];
		end
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DRAW_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold the partial remainder and the remaining dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DRAW_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

/* dv/lehmer_random_range_dice_tb.sv */
// Self-checking testbench for the random range and dice unit.
`timescale 1ns / 1ps

module lehmer_random_range_dice_tb;
	import lrrd_pkg::*;

	localparam int MAX_DICE_COUNT = 255;
	localparam int STALL_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTED = 30;
	localparam longint PM_MOD = 2147483647;
	localparam longint PM_Q = 127773;
	localparam longint PM_A = 16807;
	localparam longint PM_R = 2836;

	typedef struct {
		lrrd_op_t  op;
		bit [31:0] value;
	} draw_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [30:0] seed_value;
	logic [31:0] range_low;
	logic [31:0] range_high;
	logic [7:0]  dice_count;
	logic [15:0] dice_faces;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] value;

	bit [30:0] lcg_state;
	draw_t     pending_draws[$];
	int        send_idle_pct;
	int        recv_idle_pct;
	int        mismatch_count;
	int        results_checked;
	int        quiet_cycles;
	int        op_count[4];
	draw_t     head;

	lehmer_random_range_dice #(
		.MAX_DICE_COUNT(MAX_DICE_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.seed_value(seed_value),
		.range_low(range_low),
		.range_high(range_high),
		.dice_count(dice_count),
		.dice_faces(dice_faces),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Print one mismatch line (up to a cap) and count it
	task automatic report_mismatch(string what);
		if (mismatch_count < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $time, what);
		mismatch_count++;
	endtask

	// One generator step via the split-modulus method; zero and the modulus both map to the modulus
	function automatic bit [30:0] lcg_advance(bit [30:0] s);
		longint sv;
		longint q_hi;
		longint q_lo;
		longint t;
		sv = longint'(s);
		q_hi = sv / PM_Q;
		q_lo = sv % PM_Q;
		t = PM_A * q_lo - PM_R * q_hi;
		if (t <= 0)
			t += PM_MOD;
		return t[30:0];
	endfunction

	// Update the generator copy for one accepted item and queue its value, if any
	task automatic predict_value(lrrd_op_t op, bit [30:0] sd, bit [31:0] lo_b, bit [31:0] hi_b,
		bit [7:0] cnt, bit [15:0] fc);
		longint lo;
		longint hi;
		longint tmp;
		longint span;
		longint v;
		bit [31:0] sum;
		int n;
		draw_t e;
		e.op = op;
		e.value = '0;
		case (op)
			OP_LOAD: begin
				lcg_state = sd;
			end
			OP_RAW: begin
				lcg_state = lcg_advance(lcg_state);
				e.value = {1'b0, lcg_state};
			end
			OP_RANGE: begin
				lo = longint'($signed(lo_b));
				hi = longint'($signed(hi_b));
				if (lo == hi) begin
					e.value = lo_b;
				end else begin
					if (lo > hi) begin
						tmp = lo;
						lo = hi;
						hi = tmp;
					end
					span = hi - lo + 1;
					lcg_state = lcg_advance(lcg_state);
					v = (longint'(lcg_state) % span) + lo;
					e.value = v[31:0];
				end
			end
			default: begin
				sum = '0;
				n = (int'(cnt) > MAX_DICE_COUNT) ? MAX_DICE_COUNT : int'(cnt);
				if (n != 0 && fc != 0) begin
					for (int i = 0; i < n; i++) begin
						lcg_state = lcg_advance(lcg_state);
						sum += ({1'b0, lcg_state} % {16'd0, fc}) + 32'd1;
					end
				end
				e.value = sum;
			end
		endcase
		if (op != OP_LOAD)
			pending_draws.push_back(e);
	endtask

	// Present one item at the falling edge, hold it until accepted, then predict
	task automatic send_item(lrrd_op_t op, bit [30:0] sd, bit [31:0] lo_b, bit [31:0] hi_b,
		bit [7:0] cnt, bit [15:0] fc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		seed_value <= sd;
		range_low <= lo_b;
		range_high <= hi_b;
		dice_count <= cnt;
		dice_faces <= fc;
		do
			@(posedge clk);
		while (!in_ready);
		predict_value(op, sd, lo_b, hi_b, cnt, fc);
		op_count[op]++;
		@(negedge clk);
	endtask

	// Zero state after reset advances to the modulus and sticks there
	task automatic test_zero_state();
		send_item(OP_RAW, 31'd0, 32'd0, 32'd0, 8'd0, 16'd0);
		send_item(OP_RAW, 31'd0, 32'd0, 32'd0, 8'd0, 16'd0);
		send_item(OP_LOAD, 31'd0, 32'd0, 32'd0, 8'd0, 16'd0);
		send_item(OP_DICE, 31'd0, 32'd0, 32'd0, 8'd2, 16'd65535);
	endtask

	// Seed extremes and a plain seed
	task automatic test_seed_extremes();
		send_item(OP_LOAD, 31'd1, 32'd0, 32'd0, 8'd0, 16'd0);
		send_item(OP_RAW, 31'd0, 32'd0, 32'd0, 8'd0, 16'd0);
		send_item(OP_LOAD, 31'h7FFF_FFFF, 32'd0, 32'd0, 8'd0, 16'd0);
		send_item(OP_RAW, 31'd0, 32'd0, 32'd0, 8'd0, 16'd0);
		send_item(OP_LOAD, 31'h5555_5555, 32'd0, 32'd0, 8'd0, 16'd0);
		send_item(OP_RAW, 31'h2AAA_AAAA, 32'd0, 32'd0, 8'd0, 16'd0);
	endtask

	// Equal, reversed, adjacent and full-width bounds
	task automatic test_range_cases();
		send_item(OP_RANGE, 31'd0, 32'h8000_0000, 32'h8000_0000, 8'd0, 16'd0);
		send_item(OP_RANGE, 31'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 16'd0);
		send_item(OP_RANGE, 31'd0, 32'd10, -32'sd10, 8'd0, 16'd0);
		send_item(OP_RANGE, 31'd0, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 16'd0);
		send_item(OP_RANGE, 31'd0, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 16'd0);
		send_item(OP_RANGE, 31'd0, 32'd5, 32'd6, 8'd0, 16'd0);
	endtask

	// Zero count or faces, single face, and the largest roll
	task automatic test_dice_cases();
		send_item(OP_LOAD, 31'd12345, 32'd0, 32'd0, 8'd0, 16'd0);
		send_item(OP_DICE, 31'd0, 32'd0, 32'd0, 8'd0, 16'd6);
		send_item(OP_DICE, 31'd0, 32'd0, 32'd0, 8'd3, 16'd0);
		send_item(OP_DICE, 31'd0, 32'd0, 32'd0, 8'd1, 16'd1);
		send_item(OP_DICE, 31'd0, 32'd0, 32'd0, 8'd255, 16'd65535);
		send_item(OP_DICE, 31'd0, 32'd0, 32'd0, 8'd255, 16'd1);
		send_item(OP_DICE, 31'd0, 32'd0, 32'd0, 8'd4, 16'd6);
	endtask

	// Random mix of operations; sticky seeds and large dice counts kept rare
	task automatic test_random_mix(int n_items, int snd_pct, int rcv_pct);
		int sel;
		lrrd_op_t op;
		bit [31:0] r;
		bit [30:0] sd;
		bit [31:0] lo_b;
		bit [31:0] hi_b;
		bit [7:0] cnt;
		bit [15:0] fc;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (int k = 0; k < n_items; k++) begin
			sel = $urandom_range(99);
			op = (sel < 12) ? OP_LOAD : (sel < 40) ? OP_RAW : (sel < 72) ? OP_RANGE : OP_DICE;
			r = $urandom;
			case ($urandom_range(19))
				0: sd = 31'd0;
				1: sd = 31'h7FFF_FFFF;
				default: sd = r[30:0];
			endcase
			lo_b = $urandom;
			hi_b = $urandom;
			case ($urandom_range(9))
				0: hi_b = lo_b;
				1: hi_b = lo_b + $urandom_range(3);
				2: begin
					lo_b = 32'h8000_0000;
					hi_b = 32'h7FFF_FFFF;
				end
				3: begin
					lo_b = $urandom_range(200) - 100;
					hi_b = $urandom_range(200) - 100;
				end
				default: ;
			endcase
			r = $urandom;
			cnt = ($urandom_range(15) == 0) ? r[7:0] : 8'($urandom_range(8));
			r = $urandom;
			case ($urandom_range(9))
				0: fc = 16'd0;
				1, 2: fc = r[15:0];
				default: fc = 16'($urandom_range(20, 1));
			endcase
			send_item(op, sd, lo_b, hi_b, cnt, fc);
		end
	endtask

	// Toggle result backpressure at the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_draws.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d", $signed(value)));
			end else begin
				head = pending_draws.pop_front();
				results_checked++;
				if (value !== head.value)
					report_mismatch($sformatf("%s value: expected %0d, got %0d",
						head.op.name(), $signed(head.value), $signed(value)));
			end
		end
	end

	// End the run when no item moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_draws.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		opcode = OP_LOAD;
		seed_value = '0;
		range_low = '0;
		range_high = '0;
		dice_count = '0;
		dice_faces = '0;
		lcg_state = '0;
		mismatch_count = 0;
		results_checked = 0;
		quiet_cycles = 0;
		send_idle_pct = 22;
		recv_idle_pct = 80;
		for (int i = 0; i < 4; i++)
			op_count[i] = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_zero_state();
		test_seed_extremes();
		test_range_cases();
		test_dice_cases();
		test_random_mix(480, 22, 80);
		test_random_mix(480, 80, 22);
		test_random_mix(480, 0, 0);
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (pending_draws.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d seed loads, %0d raw draws, %0d range draws, %0d dice sums",
			op_count[OP_LOAD], op_count[OP_RAW], op_count[OP_RANGE], op_count[OP_DICE]);
		$display("%0d results checked across three backpressure patterns, %0d mismatches",
			results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lrrd_pkg.sv
hw/rtl/lrrd_lcg.sv
hw/rtl/lrrd_rem.sv
hw/rtl/lehmer_random_range_dice.sv
dv/lehmer_random_range_dice_tb.sv
